// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define WWI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define WWI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/wwi_pkg.sv =====
package wwi_pkg;

  localparam int LINE_STORE_DEPTH_DEF = 128;

  localparam logic [6:0] WRAP_COLUMN_RESET  = 7'd79;
  localparam logic [6:0] INDENT_LIMIT_RESET = 7'd72;
  localparam logic [6:0] WRAP_COLUMN_MIN    = 7'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic REG_WRAP_COLUMN  = 1'b0;
  localparam logic REG_INDENT_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_count;
    logic        add_newline;
    logic [6:0]  indent_spaces;
    logic        last_of_run;
  } result_t;

  // Classified character as it leaves the front queue
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       is_nl;
    logic       is_sp;
    logic       is_an;
  } q_item_t;

  typedef struct packed {
    logic push;
    logic fin;
  } bo_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROC,
    ST_READ,
    ST_LOAD,
    ST_DONE,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EMIT_PUSH,
    ST_FIN
  } back_state_t;

  function automatic logic is_alnum(input logic [7:0] c);
    logic r;
    r = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    return r;
  endfunction

endpackage

// ===== rtl/core/word_wrap_with_indent_core.sv =====
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | wwi_pkg::in_item_t (text_byte, end_of_text)
// out_    | output    | out_valid/out_stall | wwi_pkg::result_t (one chunk per transfer)
// cfg_    | input     | cfg_we              | cfg_index selects register, cfg_data 7 bits
// A plain character passes through dequeue, classify step, end-of-item check and run close.
// A break or newline flushes each byte through EMIT_RD and EMIT_WR, and rescans each byte
// held in the line store through READ, LOAD and PROC; both use its single read port.
// Reset (rst_n low, synchronous) empties the front queue and the line, and loads
// wrap_column 79 and indent_limit 72. A stalled output holds the back end only; the
// two-entry front queue keeps accepting until full.
module word_wrap_with_indent_core #(
  parameter int LINE_STORE_DEPTH = wwi_pkg::LINE_STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wwi_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wwi_pkg::result_t  out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  logic [6:0] wrap_column_r, wrap_column_nxt;
  logic [6:0] indent_limit_r, indent_limit_nxt;

  logic              q_valid, q_pop;
  wwi_pkg::q_item_t  q_item;
  wwi_pkg::bo_ctrl_t ctrl;
  wwi_pkg::result_t  res;
  logic              ready;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it
  always_comb begin
    wrap_column_nxt  = wrap_column_r;
    indent_limit_nxt = indent_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        wwi_pkg::REG_WRAP_COLUMN:  wrap_column_nxt  = cfg_data;
        wwi_pkg::REG_INDENT_LIMIT: indent_limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_column_r  <= wwi_pkg::WRAP_COLUMN_RESET;
      indent_limit_r <= wwi_pkg::INDENT_LIMIT_RESET;
    end else begin
      wrap_column_r  <= wrap_column_nxt;
      indent_limit_r <= indent_limit_nxt;
    end
  end

  // Front: accept and classify each transfer, hold it in a short queue
  wwi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // Back: line store, break search and chunk packing
  wwi_back #(
    .LINE_STORE_DEPTH (LINE_STORE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wrap_column  (wrap_column_r),
    .indent_limit (indent_limit_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .ctrl         (ctrl),
    .res          (res),
    .ready        (ready)
  );

  // Output: hold the newest chunk until the run's last flag is known, then register it
  wwi_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/wwi_front.sv =====
module wwi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wwi_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output wwi_pkg::q_item_t  q_item
);

  wwi_pkg::q_item_t ent_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  wwi_pkg::q_item_t cls;

  // classify the arriving character
  always_comb begin
    cls.ch    = in_data.text_byte;
    cls.eot   = in_data.end_of_text;
    cls.is_nl = (in_data.text_byte == wwi_pkg::CH_NEWLINE);
    cls.is_sp = (in_data.text_byte == wwi_pkg::CH_SPACE);
    cls.is_an = wwi_pkg::is_alnum(in_data.text_byte);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/wwi_out.sv =====
module wwi_out (
  input  logic              clk,
  input  logic              rst_n,
  input  wwi_pkg::bo_ctrl_t ctrl,
  input  wwi_pkg::result_t  res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output wwi_pkg::result_t  out_data
);

  wwi_pkg::result_t hold_r, hold_nxt;
  logic             hold_v_r, hold_v_nxt;
  wwi_pkg::result_t out_r, out_nxt;
  logic             out_v_r, out_v_nxt;
  logic             out_free;

  assign out_free  = !out_v_r || !out_stall;
  assign ready     = !hold_v_r || out_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // the held result only learns whether it closes the run when the next push or fin arrives
  always_comb begin
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_free ? 1'b0 : out_v_r;
    if (ready && (ctrl.push || ctrl.fin)) begin
      if (hold_v_r) begin
        out_nxt             = hold_r;
        out_nxt.last_of_run = ctrl.fin;
        out_v_nxt           = 1'b1;
      end
      if (ctrl.push) begin
        hold_nxt   = res;
        hold_v_nxt = 1'b1;
      end else begin
        hold_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== rtl/core/wwi_back.sv =====
`include "assert_macros.svh"

module wwi_back #(
  parameter int LINE_STORE_DEPTH = wwi_pkg::LINE_STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        wrap_column,
  input  logic [6:0]        indent_limit,
  input  logic              q_valid,
  output logic              q_pop,
  input  wwi_pkg::q_item_t  q_item,
  output wwi_pkg::bo_ctrl_t ctrl,
  output wwi_pkg::result_t  res,
  input  logic              ready
);

  localparam int MEM_N = LINE_STORE_DEPTH + 2;
  localparam int PW    = $clog2(MEM_N);
  localparam int LW    = $clog2(MEM_N + 1);
  localparam logic [5:0] MAX_RES = 6'd32;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(MEM_N - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  logic [7:0] mem [MEM_N];
  logic [7:0] rdata_r;
  logic       mem_we, rd_en;
  logic [PW-1:0] rd_addr;

  wwi_pkg::back_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [PW-1:0] a_r, a_nxt, e_r, e_nxt, s_r, s_nxt;
  logic [PW-1:0] lsep_r, lsep_nxt, q_r, q_nxt, stop_r, stop_nxt;
  logic [6:0]    col_r, col_nxt, indent_r, indent_nxt, ind_r, ind_nxt;
  logic [LW-1:0] lead_r, lead_nxt;
  logic          lead_done_r, lead_done_nxt, lsep_v_r, lsep_v_nxt;
  logic          skip_r, skip_nxt, eot_r, eot_nxt, nl_r, nl_nxt;
  logic          cnl_r, cnl_nxt, csp_r, csp_nxt, can_r, can_nxt;
  logic [63:0]   buf_r, buf_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [5:0]    nres_r, nres_nxt;

  logic [6:0]    wrap_eff;
  logic [PW-1:0] s_inc, brk_pt;
  logic          proc_skip, proc_brk, push_final;
  logic          cap_hit, push_go;
  int            ind_raw;
  logic [6:0]    ind_calc;

  always_comb begin
    if (int'(wrap_column) > LINE_STORE_DEPTH) begin
      wrap_eff = 7'(LINE_STORE_DEPTH);
    end else if (wrap_column < wwi_pkg::WRAP_COLUMN_MIN) begin
      wrap_eff = wwi_pkg::WRAP_COLUMN_MIN;
    end else begin
      wrap_eff = wrap_column;
    end
  end

  always_comb begin
    s_inc      = inc(s_r);
    proc_skip  = skip_r && csp_r;
    proc_brk   = (col_r >= wrap_eff);
    brk_pt     = lsep_v_r ? inc(lsep_r) : s_r;
    ind_raw    = (indent_r != 7'd0) ? int'(indent_r) : int'(lead_r);
    if (ind_raw >= int'(indent_limit) || ind_raw >= int'(wrap_eff)) begin
      ind_calc = 7'd0;
    end else begin
      ind_calc = 7'(ind_raw);
    end
    push_final = (q_r == stop_r);
    // drop chunks once an item has produced its full quota of results
    cap_hit    = (nres_r == MAX_RES);
    push_go    = ready || cap_hit;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wwi_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = wwi_pkg::ST_PROC;
      end
      wwi_pkg::ST_READ: state_nxt = wwi_pkg::ST_LOAD;
      wwi_pkg::ST_LOAD: state_nxt = wwi_pkg::ST_PROC;
      wwi_pkg::ST_PROC: begin
        if (proc_skip) begin
          state_nxt = (s_inc == e_r) ? wwi_pkg::ST_DONE : wwi_pkg::ST_READ;
        end else if (cnl_r || proc_brk) begin
          state_nxt = wwi_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = (s_inc == e_r) ? wwi_pkg::ST_DONE : wwi_pkg::ST_READ;
        end
      end
      wwi_pkg::ST_DONE: state_nxt = eot_r ? wwi_pkg::ST_EMIT_RD : wwi_pkg::ST_FIN;
      wwi_pkg::ST_EMIT_RD: begin
        if (q_r != stop_r) begin
          state_nxt = wwi_pkg::ST_EMIT_WR;
        end else if (cnt_r != 4'd0 || nl_r) begin
          state_nxt = wwi_pkg::ST_EMIT_PUSH;
        end else begin
          state_nxt = ret_r;
        end
      end
      wwi_pkg::ST_EMIT_WR: begin
        state_nxt = (cnt_r == 4'd7 && q_r != stop_r) ? wwi_pkg::ST_EMIT_PUSH
                                                      : wwi_pkg::ST_EMIT_RD;
      end
      wwi_pkg::ST_EMIT_PUSH: begin
        if (push_go) state_nxt = push_final ? ret_r : wwi_pkg::ST_EMIT_RD;
      end
      wwi_pkg::ST_FIN: begin
        if (ready) state_nxt = wwi_pkg::ST_IDLE;
      end
      default: state_nxt = wwi_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    a_nxt = a_r; e_nxt = e_r; s_nxt = s_r; lsep_nxt = lsep_r;
    q_nxt = q_r; stop_nxt = stop_r; col_nxt = col_r; indent_nxt = indent_r;
    ind_nxt = ind_r; lead_nxt = lead_r; lead_done_nxt = lead_done_r;
    lsep_v_nxt = lsep_v_r; skip_nxt = skip_r; eot_nxt = eot_r; nl_nxt = nl_r;
    cnl_nxt = cnl_r; csp_nxt = csp_r; can_nxt = can_r;
    buf_nxt = buf_r; cnt_nxt = cnt_r; ret_nxt = ret_r; nres_nxt = nres_r;
    mem_we = 1'b0; rd_en = 1'b0; rd_addr = s_r; q_pop = 1'b0;
    ctrl = '0;
    res.chunk_bytes   = buf_r;
    res.chunk_count   = cnt_r;
    res.add_newline   = push_final && nl_r;
    res.indent_spaces = (push_final && nl_r) ? ind_r : 7'd0;
    res.last_of_run   = 1'b0;
    case (state_r)
      wwi_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          mem_we   = 1'b1;
          cnl_nxt  = q_item.is_nl;
          csp_nxt  = q_item.is_sp;
          can_nxt  = q_item.is_an;
          eot_nxt  = q_item.eot;
          s_nxt    = e_r;
          e_nxt    = inc(e_r);
          nres_nxt = '0;
        end
      end
      wwi_pkg::ST_READ: begin
        rd_en = 1'b1;
      end
      wwi_pkg::ST_LOAD: begin
        cnl_nxt = (rdata_r == wwi_pkg::CH_NEWLINE);
        csp_nxt = (rdata_r == wwi_pkg::CH_SPACE);
        can_nxt = wwi_pkg::is_alnum(rdata_r);
      end
      wwi_pkg::ST_PROC: begin
        if (proc_skip) begin
          a_nxt = s_inc; s_nxt = s_inc;
          lead_nxt = '0; lead_done_nxt = 1'b0; lsep_v_nxt = 1'b0;
        end else begin
          skip_nxt = 1'b0;
          if (cnl_r) begin
            q_nxt = a_r; stop_nxt = s_inc; nl_nxt = 1'b0; ind_nxt = 7'd0;
            a_nxt = s_inc; s_nxt = s_inc; col_nxt = 7'd0; indent_nxt = 7'd0;
            lead_nxt = '0; lead_done_nxt = 1'b0; lsep_v_nxt = 1'b0;
            ret_nxt = (s_inc == e_r) ? wwi_pkg::ST_DONE : wwi_pkg::ST_READ;
            buf_nxt = '0; cnt_nxt = 4'd0;
          end else if (proc_brk) begin
            q_nxt = a_r; stop_nxt = brk_pt; nl_nxt = 1'b1; ind_nxt = ind_calc;
            a_nxt = brk_pt; s_nxt = brk_pt; col_nxt = ind_calc; indent_nxt = ind_calc;
            skip_nxt = 1'b1;
            lead_nxt = '0; lead_done_nxt = 1'b0; lsep_v_nxt = 1'b0;
            ret_nxt = wwi_pkg::ST_READ;
            buf_nxt = '0; cnt_nxt = 4'd0;
          end else begin
            if (!lead_done_r) begin
              if (csp_r) lead_nxt = lead_r + 1'b1;
              else       lead_done_nxt = 1'b1;
            end
            if (s_r != a_r && !can_r) begin
              lsep_nxt = s_r; lsep_v_nxt = 1'b1;
            end
            s_nxt   = s_inc;
            col_nxt = col_r + 7'd1;
          end
        end
      end
      wwi_pkg::ST_DONE: begin
        if (eot_r) begin
          q_nxt = a_r; stop_nxt = e_r; nl_nxt = 1'b0; ind_nxt = 7'd0;
          ret_nxt = wwi_pkg::ST_FIN;
          buf_nxt = '0; cnt_nxt = 4'd0;
          a_nxt = e_r; col_nxt = 7'd0; indent_nxt = 7'd0; skip_nxt = 1'b0;
          lead_nxt = '0; lead_done_nxt = 1'b0; lsep_v_nxt = 1'b0;
        end
      end
      wwi_pkg::ST_EMIT_RD: begin
        if (q_r != stop_r) begin
          rd_en   = 1'b1;
          rd_addr = q_r;
          q_nxt   = inc(q_r);
        end
      end
      wwi_pkg::ST_EMIT_WR: begin
        buf_nxt[{cnt_r[2:0], 3'b000} +: 8] = rdata_r;
        cnt_nxt = cnt_r + 4'd1;
      end
      wwi_pkg::ST_EMIT_PUSH: begin
        ctrl.push = !cap_hit;
        if (push_go) begin
          buf_nxt = '0; cnt_nxt = 4'd0;
          if (!cap_hit) nres_nxt = nres_r + 6'd1;
        end
      end
      wwi_pkg::ST_FIN: begin
        ctrl.fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wwi_pkg::ST_IDLE;
      ret_r <= wwi_pkg::ST_IDLE;
      a_r <= '0; e_r <= '0; s_r <= '0;
      col_r <= 7'd0; indent_r <= 7'd0; skip_r <= 1'b0; eot_r <= 1'b0;
      lead_r <= '0; lead_done_r <= 1'b0; lsep_v_r <= 1'b0;
      cnt_r <= 4'd0; nl_r <= 1'b0; q_r <= '0; stop_r <= '0;
      nres_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      a_r <= a_nxt; e_r <= e_nxt; s_r <= s_nxt;
      col_r <= col_nxt; indent_r <= indent_nxt; skip_r <= skip_nxt; eot_r <= eot_nxt;
      lead_r <= lead_nxt; lead_done_r <= lead_done_nxt; lsep_v_r <= lsep_v_nxt;
      cnt_r <= cnt_nxt; nl_r <= nl_nxt; q_r <= q_nxt; stop_r <= stop_nxt;
      nres_r <= nres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lsep_r <= lsep_nxt; ind_r <= ind_nxt; buf_r <= buf_nxt;
    cnl_r <= cnl_nxt; csp_r <= csp_nxt; can_r <= can_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[e_r] <= q_item.ch;
    if (rd_en)  rdata_r <= mem[rd_addr];
  end

  `WWI_ASSERT_IMPL(a_proc_has_char, state_r == wwi_pkg::ST_PROC, s_r != e_r, "scan past line end")
  `WWI_ASSERT(a_chunk_max, cnt_r <= 4'd8, "chunk overfilled")
  `WWI_ASSERT_IMPL(a_mid_chunk_full, (state_r == wwi_pkg::ST_EMIT_PUSH) && (q_r != stop_r), cnt_r == 4'd8, "short chunk before line end")

endmodule

// ===== tb/testbench.sv =====
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wwi_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wwi_pkg::result_t   out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_index = wwi_pkg::REG_WRAP_COLUMN;
  logic [6:0]         cfg_data = '0;

  word_wrap_with_indent_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wrapper state mirrored in the testbench
  logic [7:0] held_line [0:wwi_pkg::LINE_STORE_DEPTH_DEF-1];
  logic [7:0] scan_buf [0:wwi_pkg::LINE_STORE_DEPTH_DEF];
  int         held_len = 0;
  int         line_col = 0;
  int         carry_indent = 0;
  bit         eating_spaces = 1'b0;
  int         wrap_reg = 79;
  int         indent_lim_reg = 72;
  int         run_chunks;

  wwi_pkg::in_item_t text_q[$];       // bytes still to be offered
  wwi_pkg::result_t  chunk_q[$];      // chunks predicted but not yet seen
  int         errors = 0;
  bit         quiet = 1'b0;    // no idling on either side
  int         in_gap = 0;
  int         out_gap = 0;

  function automatic bit alnum_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Split a span of the scan buffer into chunks of at most eight bytes
  function automatic void queue_chunks(int start, int len, bit nl, int ind);
    wwi_pkg::result_t r;
    int      take;
    if (len == 0 && !nl) return;
    forever begin
      take = (len < 8) ? len : 8;
      r = '0;
      for (int i = 0; i < take; i++) r.chunk_bytes[8*i +: 8] = scan_buf[start + i];
      r.chunk_count = take[3:0];
      r.add_newline = (len <= 8) && nl;
      r.indent_spaces = ((len <= 8) && nl) ? ind[6:0] : 7'd0;
      if (run_chunks < 32) begin
        chunk_q.push_back(r);
        run_chunks++;
      end
      len -= take;
      start += take;
      if (len == 0) break;
    end
  endfunction

  // Advance the wrapper by one accepted byte
  function automatic void wrap_byte(wwi_pkg::in_item_t it);
    int w, n, a, s, b;
    logic [7:0] c;
    w = wrap_reg;
    a = 0;
    run_chunks = 0;
    if (w < 2) w = 2;
    if (w > wwi_pkg::LINE_STORE_DEPTH_DEF) w = wwi_pkg::LINE_STORE_DEPTH_DEF;
    n = (held_len > wwi_pkg::LINE_STORE_DEPTH_DEF) ? wwi_pkg::LINE_STORE_DEPTH_DEF : held_len;
    for (int i = 0; i < n; i++) scan_buf[i] = held_line[i];
    s = n;
    scan_buf[n] = it.text_byte;
    n++;
    while (s < n) begin
      c = scan_buf[s];
      if (eating_spaces && c == wwi_pkg::CH_SPACE) begin
        s++;
        a = s;
        continue;
      end
      eating_spaces = 1'b0;
      if (c == wwi_pkg::CH_NEWLINE) begin
        queue_chunks(a, s - a + 1, 1'b0, 0);
        s++;
        a = s;
        line_col = 0;
        carry_indent = 0;
      end else if (line_col >= w) begin
        // look back for the last non-alphanumeric character
        b = s;
        for (int j = s; j > a + 1; j--) begin
          if (!alnum_char(scan_buf[j-1])) begin
            b = j;
            break;
          end
        end
        if (carry_indent == 0)
          while (a + carry_indent < s && scan_buf[a + carry_indent] == wwi_pkg::CH_SPACE)
            carry_indent++;
        if (carry_indent >= indent_lim_reg || carry_indent >= w) carry_indent = 0;
        queue_chunks(a, b - a, 1'b1, carry_indent);
        line_col = carry_indent;
        a = b;
        s = b;
        eating_spaces = 1'b1;
      end else begin
        s++;
        line_col++;
      end
    end
    if (it.end_of_text) begin
      queue_chunks(a, n - a, 1'b0, 0);
      held_len = 0;
      line_col = 0;
      carry_indent = 0;
      eating_spaces = 1'b0;
    end else begin
      held_len = n - a;
      for (int i = 0; i < held_len; i++) held_line[i] = scan_buf[a + i];
    end
    if (run_chunks > 0) chunk_q[chunk_q.size()-1].last_of_run = 1'b1;
  endfunction

  // Input driver: predict on each transfer, then offer the next byte
  always @(posedge clk) begin
    logic              nv;
    wwi_pkg::in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        wrap_byte(in_data);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (text_q.size() > 0) begin
          nd = text_q.pop_front();
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 11);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    wwi_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (chunk_q.size() == 0) begin
          $display("%0t: unexpected chunk, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = chunk_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: chunk mismatch, expected %h, actual %h", $time, want, out_data);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put(logic [7:0] ch, bit eot = 1'b0);
    wwi_pkg::in_item_t it;
    it.text_byte = ch;
    it.end_of_text = eot;
    text_q.push_back(it);
  endtask

  task automatic put_str(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++) put(s[i], eot_last && i == s.len() - 1);
  endtask

  // Mostly words and punctuation with indented lines; a tenth is raw noise
  task automatic put_random(int count);
    int    r;
    string punct;
    punct = ",.-;:!";
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (r < 55) put(8'($urandom_range("a", "z")));
      else if (r < 62) put(8'($urandom_range("A", "Z")));
      else if (r < 67) put(8'($urandom_range("0", "9")));
      else if (r < 82) put(wwi_pkg::CH_SPACE);
      else if (r < 88) put(punct[$urandom_range(0, 5)]);
      else if (r < 94) begin
        put(wwi_pkg::CH_NEWLINE);
        repeat ($urandom_range(0, 6)) put(wwi_pkg::CH_SPACE);
      end else put(8'($urandom_range("a", "z")), $urandom_range(0, 3) == 0);
    end
  endtask

  // Only between phases: the model follows the register values
  task automatic write_regs(int wc, int il);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= wwi_pkg::REG_WRAP_COLUMN;
    cfg_data <= wc[6:0];
    @(posedge clk);
    cfg_index <= wwi_pkg::REG_INDENT_LIMIT;
    cfg_data <= il[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    wrap_reg = wc;
    indent_lim_reg = il;
  endtask

  // Hold until every byte is taken and every chunk has come, then let a
  // byte that makes no chunk finish inside the block
  task automatic drain();
    wait (text_q.size() == 0 && !in_valid);
    wait (chunk_q.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, newline flush, odd bytes, end of text
    put_str("    Hi, there\n", 1'b0);
    put(8'h00);
    put(8'hFF);
    put(8'h80);
    put_str("Az09", 1'b1);
    drain();

    // small wrap column with indent carried, cascading breaks
    write_regs(2, 1);
    put_str("  ab-cd  e", 1'b1);
    drain();
    write_regs(10, 8);
    put_str("   abcdefghijklmnopqrstu", 1'b0);
    drain();
    // lower the column while a line is held: column past wrap, empty break
    write_regs(3, 2);
    put_str("x y", 1'b1);
    drain();

    write_regs(127, 126);
    put_random(25);
    put(wwi_pkg::CH_NEWLINE, 1'b1);
    drain();
    write_regs(8, 4);
    put_random(25);
    drain();
    write_regs(2, 126);
    put_random(25);
    drain();
    write_regs(20, 3);
    put_random(25);
    drain();
    write_regs($urandom_range(2, 127), $urandom_range(1, 126));
    put_random(25);
    drain();

    quiet = 1'b1;
    write_regs(12, 72);
    put_random(25);
    put(wwi_pkg::CH_SPACE, 1'b1);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wwi_pkg.sv
rtl/core/wwi_front.sv
rtl/core/wwi_out.sv
rtl/core/wwi_back.sv
rtl/core/word_wrap_with_indent_core.sv
tb/testbench.sv
